/* rtl/los_pkg.sv */
// ----------------------------------------------------------------------------
// los_pkg
// Shared widths and types for the line-of-sight obstruction block.
// ----------------------------------------------------------------------------
package los_pkg;

  localparam int COORD_W = 16;             // Q11.4 coordinate
  localparam int DIFF_W  = COORD_W + 1;    // coordinate difference
  localparam int MUL_W   = DIFF_W + 1;     // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;      // shared multiplier product
  localparam int NUM_W   = 36;             // signed cross-product terms
  localparam int MAG_W   = 33;             // magnitude of den and tnum
  localparam int DIVD_W  = MAG_W + DIFF_W; // dividend tnum * |delta|
  localparam int QUO_W   = 16;             // quotient magnitude
  localparam int DIST_W  = 35;             // squared distance
  localparam int THR_W   = 16;             // threshold register

  localparam logic [THR_W-1:0] THR_RESET = 16'd2;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
    logic             rem_nz;
  } div_res_t;

endpackage

/* rtl/los_div.sv */
// ----------------------------------------------------------------------------
// los_div
// Restoring radix-2 divider, one quotient bit per cycle, remainder flag.
// ----------------------------------------------------------------------------
module los_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [los_pkg::DIVD_W-1:0]   dividend,
  input  logic [los_pkg::MAG_W-1:0]    divisor,
  output los_pkg::div_res_t            res
);

  logic                        busy_r;
  logic                        done_r;
  logic [3:0]                  cnt_r;
  logic [los_pkg::DIVD_W-1:0]  rem_r;
  logic [los_pkg::DIVD_W-1:0]  dsh_r;
  logic [los_pkg::QUO_W-1:0]   quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'(los_pkg::QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= {2'b00, divisor, 15'b0};
    end else if (busy_r) begin
      // subtract the shifted divisor where it fits
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[los_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[los_pkg::QUO_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign res.done   = done_r;
  assign res.quot   = quo_r;
  assign res.rem_nz = (rem_r != '0);

endmodule

/* rtl/line_of_sight_obstruction.sv */
// ----------------------------------------------------------------------------
// line_of_sight_obstruction
// Segment intersection against a latched viewer-target query, nearest hit.
// ----------------------------------------------------------------------------
// Sequence: a segment that misses runs the cross products and the check and is
// ready again; a hit adds two divisions on the shared divider plus 18x18
// multiplier steps; a last item adds the target distance before the result.
// Throughput: one item at a time, in_tready only when the sequencer is idle.
// Reset (rst_n, synchronous): sequencer idle, no run open, no result
// pending, threshold back to 2.
module line_of_sight_obstruction (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,   // min_hit_dist_sq
  input  logic         in_tvalid,
  output logic         in_tready,
  // view_x, view_y, target_x, target_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,      // is_last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,     // hit_x, hit_y
  output logic [1:0]   out_tuser      // hit_found, blocked
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CROSS = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_SCALE = 4'd3;
  localparam logic [3:0] ST_DIVS  = 4'd4;
  localparam logic [3:0] ST_DIVW  = 4'd5;
  localparam logic [3:0] ST_SQR   = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_TGT   = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  localparam int CW = los_pkg::COORD_W;
  localparam int DW = los_pkg::DIFF_W;

  logic [3:0]                   state_r;
  logic [2:0]                   cnt_r;
  logic                         axis_r;
  logic                         in_run_r;
  logic                         last_r;
  logic [los_pkg::THR_W-1:0]    thr_r;
  logic signed [CW-1:0]         vx_r, vy_r, tx_r, ty_r;
  logic signed [CW-1:0]         ax_r, ay_r, bx_r, by_r;
  logic [los_pkg::DIST_W-1:0]   best_r;
  logic signed [CW-1:0]         bpx_r, bpy_r;
  logic                         have_r;
  logic signed [los_pkg::NUM_W-1:0] acc_r, den_r, tnum_r, unum_r;
  logic [los_pkg::DIVD_W-1:0]   prod_r;
  logic signed [DW-1:0]         qx_r, qy_r;
  logic                         out_valid_r;
  logic [31:0]                  out_data_r;
  logic [1:0]                   out_user_r;

  logic signed [DW-1:0] d12x, d12y, d34x, d34y, d13x, d13y, delta;
  logic [DW-1:0]        mag;
  logic                 dneg;
  logic signed [los_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [los_pkg::PROD_W-1:0] prod;
  logic                 den_neg, hit;
  logic signed [los_pkg::NUM_W-1:0]  dabs, tfix, ufix;
  logic signed [DW-1:0] qfix;
  logic [los_pkg::DIST_W-1:0] hit_dsq;
  logic                 div_start;
  los_pkg::div_res_t    div_res;

  assign d12x = DW'(vx_r) - DW'(tx_r);
  assign d12y = DW'(vy_r) - DW'(ty_r);
  assign d34x = DW'(ax_r) - DW'(bx_r);
  assign d34y = DW'(ay_r) - DW'(by_r);
  assign d13x = DW'(vx_r) - DW'(ax_r);
  assign d13y = DW'(vy_r) - DW'(ay_r);

  assign delta = axis_r ? -d12y : -d12x;
  assign dneg  = delta[DW-1];
  assign mag   = dneg ? DW'(-delta) : DW'(delta);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_CROSS: begin
        unique case (cnt_r)
          3'd0:    begin mul_a = 18'(d13x); mul_b = 18'(d34y); end
          3'd1:    begin mul_a = 18'(d13y); mul_b = 18'(d34x); end
          3'd2:    begin mul_a = 18'(d12x); mul_b = 18'(d34y); end
          3'd3:    begin mul_a = 18'(d12y); mul_b = 18'(d34x); end
          3'd4:    begin mul_a = 18'(d13x); mul_b = 18'(d12y); end
          default: begin mul_a = 18'(d13y); mul_b = 18'(d12x); end
        endcase
      end
      ST_SCALE: begin
        mul_b = {1'b0, mag};
        if (cnt_r == 3'd0) begin
          mul_a = {1'b0, tnum_r[16:0]};
        end else begin
          mul_a = {2'b00, tnum_r[32:17]};
        end
      end
      ST_SQR: begin
        mul_a = (cnt_r == 3'd0) ? 18'(qx_r) : 18'(qy_r);
        mul_b = mul_a;
      end
      ST_TGT: begin
        mul_a = (cnt_r == 3'd0) ? 18'(d12x) : 18'(d12y);
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign den_neg = den_r[los_pkg::NUM_W-1];
  assign dabs    = den_neg ? -den_r  : den_r;
  assign tfix    = den_neg ? -tnum_r : tnum_r;
  assign ufix    = den_neg ? -unum_r : unum_r;
  assign hit     = (dabs != '0) && !tfix[los_pkg::NUM_W-1] && (tfix <= dabs)
                   && !ufix[los_pkg::NUM_W-1] && (ufix <= dabs);

  // floor division: round down when the quotient is negative and inexact
  assign qfix = dneg ? (-DW'({1'b0, div_res.quot}) - DW'(div_res.rem_nz))
                     : DW'({1'b0, div_res.quot});

  assign hit_dsq   = acc_r[los_pkg::DIST_W-1:0];
  assign div_start = (state_r == ST_DIVS);

  los_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (den_r[los_pkg::MAG_W-1:0]),
    .res      (div_res)
  );

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      axis_r      <= 1'b0;
      in_run_r    <= 1'b0;
      thr_r       <= los_pkg::THR_RESET;
      best_r      <= '1;
      bpx_r       <= '0;
      bpy_r       <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            if (!in_run_r) begin
              vx_r     <= in_tdata[15:0];
              vy_r     <= in_tdata[31:16];
              tx_r     <= in_tdata[47:32];
              ty_r     <= in_tdata[63:48];
              best_r   <= '1;
              bpx_r    <= '0;
              bpy_r    <= '0;
              have_r   <= 1'b0;
              in_run_r <= 1'b1;
            end
            ax_r    <= in_tdata[79:64];
            ay_r    <= in_tdata[95:80];
            bx_r    <= in_tdata[111:96];
            by_r    <= in_tdata[127:112];
            last_r  <= in_tlast;
            cnt_r   <= '0;
            state_r <= ST_CROSS;
          end
        end
        ST_CROSS: begin
          cnt_r <= cnt_r + 3'd1;
          if (!cnt_r[0]) begin
            acc_r <= los_pkg::NUM_W'(prod);
          end else begin
            unique case (cnt_r)
              3'd1:    tnum_r <= acc_r - los_pkg::NUM_W'(prod);
              3'd3:    den_r  <= acc_r - los_pkg::NUM_W'(prod);
              default: unum_r <= acc_r - los_pkg::NUM_W'(prod);
            endcase
            if (cnt_r == 3'd5) begin
              state_r <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          den_r  <= dabs;
          tnum_r <= tfix;
          axis_r <= 1'b0;
          cnt_r  <= '0;
          if (hit) begin
            state_r <= ST_SCALE;
          end else begin
            state_r <= last_r ? ST_TGT : ST_IDLE;
          end
        end
        ST_SCALE: begin
          if (cnt_r == 3'd0) begin
            prod_r <= los_pkg::DIVD_W'(prod[33:0]);
            cnt_r  <= 3'd1;
          end else begin
            prod_r  <= prod_r + {prod[32:0], 17'b0};
            state_r <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_res.done) begin
            cnt_r <= '0;
            if (!axis_r) begin
              qx_r    <= qfix;
              axis_r  <= 1'b1;
              state_r <= ST_SCALE;
            end else begin
              qy_r    <= qfix;
              state_r <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (cnt_r == 3'd0) begin
            acc_r <= los_pkg::NUM_W'(prod);
            cnt_r <= 3'd1;
          end else begin
            acc_r   <= acc_r + los_pkg::NUM_W'(prod);
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          // keep the earlier hit on a tie
          if ((hit_dsq > los_pkg::DIST_W'(thr_r)) && (hit_dsq < best_r)) begin
            best_r <= hit_dsq;
            bpx_r  <= vx_r + qx_r[CW-1:0];
            bpy_r  <= vy_r + qy_r[CW-1:0];
            have_r <= 1'b1;
          end
          cnt_r   <= '0;
          state_r <= last_r ? ST_TGT : ST_IDLE;
        end
        ST_TGT: begin
          if (cnt_r == 3'd0) begin
            acc_r <= los_pkg::NUM_W'(prod);
            cnt_r <= 3'd1;
          end else begin
            acc_r   <= acc_r + los_pkg::NUM_W'(prod);
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold until the previous result has been taken
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {bpy_r, bpx_r};
            out_user_r  <= {have_r && (best_r < hit_dsq), have_r};
            in_run_r    <= 1'b0;
            best_r      <= '1;
            bpx_r       <= '0;
            bpy_r       <= '0;
            have_r      <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
